### rtl/csc_pkg.sv
`timescale 1ns / 1ps

package csc_pkg;

	localparam int VAL_W = 31;
	localparam int LIM_W = 30;
	localparam int RES_W = 2 * VAL_W;
	localparam int STACK_DEPTH_DEF = 1024;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 30'd1000000000;

	typedef enum logic [3:0] {
		FN_START = 4'd0,
		FN_NUM   = 4'd1,
		FN_POP   = 4'd2,
		FN_INV   = 4'd3,
		FN_DUP   = 4'd4,
		FN_SWP   = 4'd5,
		FN_ADD   = 4'd6,
		FN_SUB   = 4'd7,
		FN_MUL   = 4'd8,
		FN_DIV   = 4'd9,
		FN_MOD   = 4'd10,
		FN_END   = 4'd11
	} func_t;

	typedef enum logic [1:0] {
		AS_TOP,
		AS_NEXT,
		AS_BASE
	} addr_sel_t;

	typedef enum logic [2:0] {
		SRC_OPV,
		SRC_RD,
		SRC_NEG_RD,
		SRC_B,
		SRC_R
	} src_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_QUO,
		ALU_REM
	} alu_t;

	typedef struct packed {
		logic      latch;
		logic      clear;
		logic      rd;
		addr_sel_t rd_addr;
		logic      cap_b;
		logic      cap_a;
		logic      push;
		src_t      push_src;
		logic      wr;
		addr_sel_t wr_addr;
		src_t      wr_src;
		logic      pop1;
		logic      pop2;
		logic      set_err;
		logic      alu;
		alu_t      alu_op;
		logic      div_start;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic lt2;
		logic one;
		logic err;
		logic b_zero;
		logic div_done;
	} stat_t;

endpackage

### rtl/csc_req_if.sv
`timescale 1ns / 1ps

interface csc_req_if;
	logic                               valid;
	logic                               ready;
	logic [3:0]                         func;
	logic signed [csc_pkg::VAL_W-1:0]   operand_value;

	modport source(output valid, func, operand_value, input ready);
	modport sink(input valid, func, operand_value, output ready);
endinterface

### rtl/csc_rsp_if.sv
`timescale 1ns / 1ps

interface csc_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [csc_pkg::VAL_W-1:0]   final_value;
	logic                               is_error;

	modport source(output valid, final_value, is_error, input ready);
	modport sink(input valid, final_value, is_error, output ready);
endinterface

### rtl/csc_cfg_if.sv
`timescale 1ns / 1ps

interface csc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [csc_pkg::LIM_W-1:0]    magnitude_limit;

	modport source(output valid, magnitude_limit, input ready);
	modport sink(input valid, magnitude_limit, output ready);
endinterface

### rtl/csc_div.sv
`timescale 1ns / 1ps

module csc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [csc_pkg::VAL_W-1:0]   dividend,
	input  logic [csc_pkg::VAL_W-1:0]   divisor,
	output logic                        done,
	output logic [csc_pkg::VAL_W-1:0]   quo,
	output logic [csc_pkg::VAL_W-1:0]   rem
);
	localparam int W = csc_pkg::VAL_W;
	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	always_comb begin
		shifted = {rem_q[W-1:0], quo_q[W-1]};
		diff = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	// one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q[W-1:0];
endmodule

### rtl/csc_ctrl.sv
`timescale 1ns / 1ps

module csc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [3:0]            req_func,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output csc_pkg::cmd_t         cmd,
	input  csc_pkg::stat_t        stat
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_ONE,
		S_RD2,
		S_RD3,
		S_SWP2,
		S_ALU,
		S_DIVGO,
		S_DIVW,
		S_PUSH,
		S_OUT
	} state_t;

	state_t          state_q, state_d;
	csc_pkg::func_t  func_q;
	logic            out_valid_q;
	logic            is_div;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign is_div = (func_q == csc_pkg::FN_DIV) || (func_q == csc_pkg::FN_MOD);

	always_comb begin
		cmd = '0;
		cmd.rd_addr = csc_pkg::AS_TOP;
		cmd.wr_addr = csc_pkg::AS_TOP;
		cmd.push_src = csc_pkg::SRC_OPV;
		cmd.wr_src = csc_pkg::SRC_RD;
		cmd.alu_op = csc_pkg::ALU_ADD;
		unique case (func_q)
			csc_pkg::FN_SUB: cmd.alu_op = csc_pkg::ALU_SUB;
			csc_pkg::FN_MUL: cmd.alu_op = csc_pkg::ALU_MUL;
			csc_pkg::FN_DIV: cmd.alu_op = csc_pkg::ALU_QUO;
			csc_pkg::FN_MOD: cmd.alu_op = csc_pkg::ALU_REM;
			default: cmd.alu_op = csc_pkg::ALU_ADD;
		endcase
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (func_q == csc_pkg::FN_START) begin
					cmd.clear = 1'b1;
					cmd.push = 1'b1;
				end else if (func_q == csc_pkg::FN_END) begin
					cmd.rd = 1'b1;
					cmd.rd_addr = csc_pkg::AS_BASE;
					state_d = S_OUT;
				end else if (!stat.err) begin
					unique case (func_q)
						csc_pkg::FN_NUM: cmd.push = 1'b1;
						csc_pkg::FN_POP: begin
							cmd.set_err = stat.empty;
							cmd.pop1 = !stat.empty;
						end
						csc_pkg::FN_INV, csc_pkg::FN_DUP: begin
							if (stat.empty) begin
								cmd.set_err = 1'b1;
							end else begin
								cmd.rd = 1'b1;
								state_d = S_ONE;
							end
						end
						csc_pkg::FN_SWP, csc_pkg::FN_ADD, csc_pkg::FN_SUB,
						csc_pkg::FN_MUL, csc_pkg::FN_DIV, csc_pkg::FN_MOD: begin
							if (stat.lt2) begin
								cmd.set_err = 1'b1;
							end else begin
								cmd.rd = 1'b1;
								state_d = S_RD2;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ONE: begin
				if (func_q == csc_pkg::FN_INV) begin
					cmd.wr = 1'b1;
					cmd.wr_src = csc_pkg::SRC_NEG_RD;
				end else begin
					cmd.push = 1'b1;
					cmd.push_src = csc_pkg::SRC_RD;
				end
				state_d = S_IDLE;
			end
			S_RD2: begin
				cmd.cap_b = 1'b1;
				cmd.rd = 1'b1;
				cmd.rd_addr = csc_pkg::AS_NEXT;
				state_d = S_RD3;
			end
			S_RD3: begin
				cmd.cap_a = 1'b1;
				if (func_q == csc_pkg::FN_SWP) begin
					cmd.wr = 1'b1;
					state_d = S_SWP2;
				end else begin
					cmd.pop2 = 1'b1;
					if (is_div && stat.b_zero) begin
						cmd.set_err = 1'b1;
						state_d = S_IDLE;
					end else if (is_div) begin
						state_d = S_DIVGO;
					end else begin
						state_d = S_ALU;
					end
				end
			end
			S_SWP2: begin
				cmd.wr = 1'b1;
				cmd.wr_addr = csc_pkg::AS_NEXT;
				cmd.wr_src = csc_pkg::SRC_B;
				state_d = S_IDLE;
			end
			S_ALU: begin
				cmd.alu = 1'b1;
				state_d = S_PUSH;
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (stat.div_done) begin
					cmd.alu = 1'b1;
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				cmd.push_src = csc_pkg::SRC_R;
				state_d = S_IDLE;
			end
			S_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= csc_pkg::FN_START;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.latch) begin
				func_q <= csc_pkg::func_t'(req_func);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### rtl/csc_datapath.sv
`timescale 1ns / 1ps

module csc_datapath #(
	parameter int STACK_DEPTH = csc_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  csc_pkg::cmd_t                      cmd,
	output csc_pkg::stat_t                     stat,
	input  logic signed [csc_pkg::VAL_W-1:0]   operand_value,
	input  logic                               cfg_valid,
	input  logic [csc_pkg::LIM_W-1:0]          cfg_limit,
	output logic signed [csc_pkg::VAL_W-1:0]   final_value,
	output logic                               is_error
);
	localparam int VW = csc_pkg::VAL_W;
	localparam int RW = csc_pkg::RES_W;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

	logic [VW-1:0]           mem [STACK_DEPTH];
	logic [VW-1:0]           rd_q;
	logic [VW-1:0]           opv_q;
	logic [VW-1:0]           a_q;
	logic [VW-1:0]           b_q;
	logic signed [RW-1:0]    r_q;
	logic [DW-1:0]           depth_q, depth_d, dbase;
	logic                    err_q, err_d;
	logic [csc_pkg::LIM_W-1:0] limit_q;
	logic signed [VW-1:0]    final_value_q;
	logic                    is_error_q;

	logic [AW-1:0]           top_addr, next_addr, rd_addr, wr_addr_sel, mem_wa;
	logic [VW-1:0]           mem_wd, wr_val;
	logic                    mem_we;
	logic signed [RW-1:0]    push_val, push_mag, r_d;
	logic                    push_big, push_ok;
	logic [VW-1:0]           a_mag, b_mag, quo, rem;
	logic                    div_done;
	logic signed [RW-1:0]    a_ext, b_ext, quo_ext, rem_ext;

	function automatic logic signed [RW-1:0] sext(input logic [VW-1:0] v);
		return {{(RW - VW){v[VW-1]}}, v};
	endfunction

	csc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(a_mag),
		.divisor (b_mag),
		.done    (div_done),
		.quo     (quo),
		.rem     (rem)
	);

	always_comb begin
		top_addr = AW'(depth_q - DW'(1));
		next_addr = AW'(depth_q - DW'(2));
		unique case (cmd.rd_addr)
			csc_pkg::AS_TOP:  rd_addr = top_addr;
			csc_pkg::AS_NEXT: rd_addr = next_addr;
			default:          rd_addr = '0;
		endcase
		unique case (cmd.wr_addr)
			csc_pkg::AS_TOP:  wr_addr_sel = top_addr;
			csc_pkg::AS_NEXT: wr_addr_sel = next_addr;
			default:          wr_addr_sel = '0;
		endcase
		unique case (cmd.wr_src)
			csc_pkg::SRC_NEG_RD: wr_val = -rd_q;
			csc_pkg::SRC_B:      wr_val = b_q;
			default:             wr_val = rd_q;
		endcase
		unique case (cmd.push_src)
			csc_pkg::SRC_RD: push_val = sext(rd_q);
			csc_pkg::SRC_R:  push_val = r_q;
			default:         push_val = sext(opv_q);
		endcase

		push_mag = push_val[RW-1] ? -push_val : push_val;
		push_big = push_mag > RW'(limit_q);
		dbase = cmd.clear ? '0 : depth_q;
		push_ok = cmd.push && !push_big && (dbase != FULL);

		mem_we = push_ok || cmd.wr;
		mem_wa = push_ok ? dbase[AW-1:0] : wr_addr_sel;
		mem_wd = push_ok ? push_val[VW-1:0] : wr_val;

		depth_d = dbase;
		if (push_ok) begin
			depth_d = dbase + DW'(1);
		end else if (cmd.pop1) begin
			depth_d = depth_q - DW'(1);
		end else if (cmd.pop2) begin
			depth_d = depth_q - DW'(2);
		end
		err_d = cmd.clear ? 1'b0 : err_q;
		if ((cmd.push && !push_ok) || cmd.set_err) begin
			err_d = 1'b1;
		end

		// entries never exceed the limit in force when pushed, so magnitudes fit the value width
		a_mag = a_q[VW-1] ? -a_q : a_q;
		b_mag = b_q[VW-1] ? -b_q : b_q;
		a_ext = sext(a_q);
		b_ext = sext(b_q);
		quo_ext = (a_q[VW-1] ^ b_q[VW-1]) ? -RW'(quo) : RW'(quo);
		rem_ext = a_q[VW-1] ? -RW'(rem) : RW'(rem);
		unique case (cmd.alu_op)
			csc_pkg::ALU_SUB: r_d = a_ext - b_ext;
			csc_pkg::ALU_MUL: r_d = $signed(a_q) * $signed(b_q);
			csc_pkg::ALU_QUO: r_d = quo_ext;
			csc_pkg::ALU_REM: r_d = rem_ext;
			default:          r_d = a_ext + b_ext;
		endcase

		stat.empty = (depth_q == '0);
		stat.lt2 = (depth_q < DW'(2));
		stat.one = (depth_q == DW'(1));
		stat.err = err_q;
		stat.b_zero = (b_q == '0);
		stat.div_done = div_done;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			opv_q <= operand_value;
		end
		if (cmd.cap_b) begin
			b_q <= rd_q;
		end
		if (cmd.cap_a) begin
			a_q <= rd_q;
		end
		if (cmd.alu) begin
			r_q <= r_d;
		end
		if (cmd.out_load) begin
			is_error_q <= err_q || (depth_q != DW'(1));
			final_value_q <= (err_q || (depth_q != DW'(1))) ? '0 : rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			err_q <= 1'b0;
			limit_q <= csc_pkg::LIMIT_RESET;
		end else begin
			depth_q <= depth_d;
			err_q <= err_d;
			if (cfg_valid) begin
				limit_q <= cfg_limit;
			end
		end
	end

	assign final_value = final_value_q;
	assign is_error = is_error_q;
endmodule

### rtl/checked_stack_calculator_core.sv
`timescale 1ns / 1ps

// Checked integer stack calculator. Each request on req carries one
// instruction (func) and an operand used by START and NUM. Results leave on
// rsp only for END: the sole stack entry, or is_error with a zero value.
// cfg writes the magnitude limit; it is always ready. The user must write it
// only while no instruction is in flight; the block does not enforce this.
// Flow: one instruction at a time. DIV and MOD use the bit-serial divider
// (one quotient bit per cycle, 31 bits), which is skipped when the divisor
// is zero. END loads its result into the output register.
// The stack lives in a single-port-write, single-read memory, so operands
// are read one at a time.
// Reset clears depth, error flag and limit (to 1000000000); the stack
// memory is not cleared. If rsp stalls, the result waits in the output
// register while later requests are accepted; a second END waits until the
// first result is taken.
module checked_stack_calculator_core #(
	parameter int STACK_DEPTH = csc_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	csc_req_if.sink     req,
	csc_rsp_if.source   rsp,
	csc_cfg_if.sink     cfg
);
	csc_pkg::cmd_t  cmd;
	csc_pkg::stat_t stat;

	assign cfg.ready = 1'b1;

	csc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_func (req.func),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	csc_datapath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operand_value(req.operand_value),
		.cfg_valid    (cfg.valid),
		.cfg_limit    (cfg.magnitude_limit),
		.final_value  (rsp.final_value),
		.is_error     (rsp.is_error)
	);
endmodule

### test/checked_stack_calculator_core_test.sv
`timescale 1ns / 1ps

module checked_stack_calculator_core_test;

	localparam int DEPTH = 1024;
	localparam int LIMIT_CYCLES = 1000000;

	logic clk;
	logic arst_n;

	csc_req_if req ();
	csc_rsp_if rsp ();
	csc_cfg_if cfg ();

	checked_stack_calculator_core #(.STACK_DEPTH(DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	typedef struct packed {
		logic signed [csc_pkg::VAL_W-1:0] value;
		logic                             err;
	} outcome_t;

	// shadow calculator state
	logic signed [csc_pkg::VAL_W-1:0] calc_stack [DEPTH];
	int unsigned                      calc_depth;
	bit                               calc_err;
	logic [csc_pkg::LIM_W-1:0]        calc_limit;

	outcome_t pending_outcomes[$];
	int       send_idle_pct;
	int       recv_idle_pct;
	int       mismatches;
	int       outcomes_seen;
	int       requests_sent;

	function automatic bit out_of_range(longint v);
		longint m;
		m = v < 0 ? -v : v;
		return m > longint'(calc_limit);
	endfunction

	function automatic void calc_push(longint v);
		if (out_of_range(v) || calc_depth >= DEPTH) begin
			calc_err = 1'b1;
		end else begin
			calc_stack[calc_depth] = v[csc_pkg::VAL_W-1:0];
			calc_depth++;
		end
	endfunction

	function automatic void calc_execute(logic [3:0] fn,
		logic signed [csc_pkg::VAL_W-1:0] opv);
		longint a;
		longint b;
		longint r;
		outcome_t o;
		if (fn == csc_pkg::FN_START) begin
			calc_depth = 0;
			calc_err = 1'b0;
			calc_push(longint'(opv));
			return;
		end
		if (fn == csc_pkg::FN_END) begin
			if (calc_err || calc_depth != 1) begin
				o.value = '0;
				o.err = 1'b1;
			end else begin
				o.value = calc_stack[0];
				o.err = 1'b0;
			end
			pending_outcomes.insert(pending_outcomes.size(), o);
			return;
		end
		if (fn > csc_pkg::FN_END || calc_err)
			return;
		case (fn)
			csc_pkg::FN_NUM: calc_push(longint'(opv));
			csc_pkg::FN_POP: begin
				if (calc_depth < 1) calc_err = 1'b1;
				else calc_depth--;
			end
			csc_pkg::FN_INV: begin
				if (calc_depth < 1) calc_err = 1'b1;
				else calc_stack[calc_depth-1] = -calc_stack[calc_depth-1];
			end
			csc_pkg::FN_DUP: begin
				if (calc_depth < 1) calc_err = 1'b1;
				else calc_push(longint'(calc_stack[calc_depth-1]));
			end
			csc_pkg::FN_SWP: begin
				if (calc_depth < 2) begin
					calc_err = 1'b1;
				end else begin
					a = longint'(calc_stack[calc_depth-1]);
					calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
					calc_stack[calc_depth-2] = a[csc_pkg::VAL_W-1:0];
				end
			end
			default: begin
				if (calc_depth < 2) begin
					calc_err = 1'b1;
				end else begin
					b = longint'(calc_stack[calc_depth-1]);
					a = longint'(calc_stack[calc_depth-2]);
					calc_depth -= 2;
					if ((fn == csc_pkg::FN_DIV || fn == csc_pkg::FN_MOD) && b == 0) begin
						calc_err = 1'b1;
					end else begin
						case (fn)
							csc_pkg::FN_ADD: r = a + b;
							csc_pkg::FN_SUB: r = a - b;
							csc_pkg::FN_MUL: r = a * b;
							csc_pkg::FN_DIV: r = a / b;
							default: r = a % b;
						endcase
						calc_push(r);
					end
				end
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one instruction request; idles before it at the current sender rate
	task automatic send_instr(logic [3:0] fn, logic signed [csc_pkg::VAL_W-1:0] opv);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= fn;
		req.operand_value <= opv;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		calc_execute(fn, opv);
		requests_sent++;
	endtask

	task automatic hold_idle();
		req.valid <= 1'b0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		hold_idle();
		while (pending_outcomes.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
	endtask

	task automatic write_limit(logic [csc_pkg::LIM_W-1:0] lim);
		drain();
		cfg.valid <= 1'b1;
		cfg.magnitude_limit <= lim;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		calc_limit = lim;
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (rsp.valid && rsp.ready) begin
			outcomes_seen++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: want none, got value=%0d err=%0b",
						rsp.final_value, rsp.is_error);
			end else begin
				want = pending_outcomes.pop_front();
				if (want.value !== rsp.final_value || want.err !== rsp.is_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: want value=%0d err=%0b, got value=%0d err=%0b",
							want.value, want.err, rsp.final_value, rsp.is_error);
				end
			end
		end
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic signed [csc_pkg::VAL_W-1:0] pick_value(
		logic [csc_pkg::LIM_W-1:0] lim);
		int unsigned k;
		k = $urandom_range(9);
		if (k < 4) return csc_pkg::VAL_W'(int'($urandom_range(200)) - 100);
		if (k < 6) return csc_pkg::VAL_W'($urandom_range(lim));
		if (k < 8) return csc_pkg::VAL_W'(-longint'($urandom_range(lim)));
		return csc_pkg::VAL_W'($urandom);
	endfunction

	task automatic test_directed();
		send_instr(csc_pkg::FN_START, 31'sd7);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, -31'sd1073741823 - 31'sd1);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd1000000000);
		send_instr(csc_pkg::FN_NUM, -31'sd1000000000);
		send_instr(csc_pkg::FN_ADD, '0);
		send_instr(csc_pkg::FN_NUM, 31'sd1073741823);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd20);
		send_instr(csc_pkg::FN_NUM, 31'sd3);
		send_instr(csc_pkg::FN_SWP, '0);
		send_instr(csc_pkg::FN_INV, '0);
		send_instr(csc_pkg::FN_DUP, '0);
		send_instr(csc_pkg::FN_MUL, '0);
		send_instr(csc_pkg::FN_POP, '0);
		send_instr(csc_pkg::FN_NUM, -31'sd7);
		send_instr(csc_pkg::FN_DIV, '0);
		send_instr(csc_pkg::FN_NUM, 31'sd2);
		send_instr(csc_pkg::FN_MOD, '0);
		send_instr(4'd13, 31'sd5);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd1);
		send_instr(csc_pkg::FN_NUM, '0);
		send_instr(csc_pkg::FN_DIV, '0);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd9);
		send_instr(csc_pkg::FN_NUM, '0);
		send_instr(csc_pkg::FN_MOD, '0);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, '0);
		send_instr(csc_pkg::FN_POP, '0);
		send_instr(csc_pkg::FN_POP, '0);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd2);
		send_instr(csc_pkg::FN_SUB, '0);
		send_instr(csc_pkg::FN_END, '0);
	endtask

	// fill the stack to the top, overflow it, then restart on the full stack
	task automatic test_overflow();
		send_instr(csc_pkg::FN_START, 31'sd1);
		repeat (DEPTH - 1) send_instr(csc_pkg::FN_DUP, '0);
		send_instr(csc_pkg::FN_NUM, 31'sd4);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd5);
		send_instr(csc_pkg::FN_END, '0);
	endtask

	task automatic test_programs(int n_items);
		int sent;
		int len;
		int unsigned sel;
		logic [3:0] fn;
		sent = 0;
		while (sent < n_items) begin
			len = int'($urandom_range(8, 1));
			send_instr(csc_pkg::FN_START, pick_value(calc_limit));
			sent++;
			repeat (len) begin
				sel = $urandom_range(99);
				if (sel < 8) fn = 4'($urandom_range(15, 12));
				else if (calc_depth < 2 && sel < 70) fn = csc_pkg::FN_NUM;
				else if (sel < 85) fn = 4'($urandom_range(10, 6));
				else fn = 4'($urandom_range(11, 1));
				send_instr(fn, pick_value(calc_limit));
				sent++;
			end
			// mostly collapse to one entry so END returns a value
			while (calc_depth > 1 && !calc_err && $urandom_range(9) != 0) begin
				send_instr(4'($urandom_range(10, 6)), '0);
				sent++;
			end
			send_instr(csc_pkg::FN_END, '0);
			sent++;
		end
	endtask

	task automatic test_limit_change();
		send_instr(csc_pkg::FN_START, 31'sd500);
		send_instr(csc_pkg::FN_NUM, 31'sd400);
		write_limit(30'd100);
		send_instr(csc_pkg::FN_ADD, '0);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd100);
		send_instr(csc_pkg::FN_END, '0);
		write_limit(30'd0);
		send_instr(csc_pkg::FN_START, '0);
		send_instr(csc_pkg::FN_DUP, '0);
		send_instr(csc_pkg::FN_ADD, '0);
		send_instr(csc_pkg::FN_END, '0);
		send_instr(csc_pkg::FN_START, 31'sd1);
		send_instr(csc_pkg::FN_END, '0);
		write_limit(30'h3FFFFFFF);
		send_instr(csc_pkg::FN_START, -31'sd1073741823);
		send_instr(csc_pkg::FN_NUM, 31'sd1073741823);
		send_instr(csc_pkg::FN_END, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = csc_pkg::FN_START;
		req.operand_value = '0;
		cfg.valid = 1'b0;
		cfg.magnitude_limit = csc_pkg::LIMIT_RESET;
		calc_depth = 0;
		calc_err = 1'b0;
		calc_limit = csc_pkg::LIMIT_RESET;
		mismatches = 0;
		outcomes_seen = 0;
		requests_sent = 0;
		send_idle_pct = 31;
		recv_idle_pct = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overflow();
		test_programs(30);
		drain();
		send_idle_pct = 50;
		recv_idle_pct = 31;
		write_limit(30'd1000);
		test_programs(30);
		test_limit_change();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(30'h3FFFFFFF);
		test_programs(20);
		write_limit(csc_pkg::LIMIT_RESET);
		test_programs(20);
		drain();

		$display("ran %0d instructions and checked %0d END results: every opcode,",
			requests_sent, outcomes_seen);
		$display("stack overflow and restart, limit rewrites from 0 to full scale");
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				pending_outcomes.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#(2 * LIMIT_CYCLES);
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
rtl/csc_pkg.sv
rtl/csc_req_if.sv
rtl/csc_rsp_if.sv
rtl/csc_cfg_if.sv
rtl/csc_div.sv
rtl/csc_ctrl.sv
rtl/csc_datapath.sv
rtl/checked_stack_calculator_core.sv
test/checked_stack_calculator_core_test.sv
